### rtl/core/frg_pkg.sv
// Shared types and defaults for the fraction reducer.
// Holds the divider status struct and the sequencer state encoding.
// No dependencies.
package frg_pkg;

    localparam int VALUE_WIDTH_DEF = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } frg_div_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_REM  = 5'b00010,
        ST_QN   = 5'b00100,
        ST_QD   = 5'b01000,
        ST_DONE = 5'b10000
    } frg_state_t;

endpackage

### rtl/core/frg_div.sv
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on frg_pkg for the status struct.
module frg_div import frg_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output frg_div_status_t        status,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] dq_reg,  dq_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   ge;

    assign trial = {rem_reg, dq_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start && cnt_reg == '0) begin
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = CW'(VALUE_WIDTH);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            dq_next   = {dq_reg[VALUE_WIDTH-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign status.busy = cnt_reg != '0;
    assign status.done = done_reg;
    assign quotient    = dq_reg;
    assign remainder   = rem_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !status.busy)
        else $error("divider started while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> status.busy)
        else $error("divider did not start");
    a_done_end: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done |-> !status.busy && $past(status.busy))
        else $error("divider done outside a run");
`endif

endmodule

### rtl/core/fraction_reduce_gcd.sv
// Fraction reducer: Euclid remainder loop on a shared serial divider.
// Sequencer, sign handling and output register. Depends on frg_pkg, frg_div.
//
// Usage: a request on s_ carries numerator and denominator; one result on m_
// carries both quotients by the common divisor and the divisor itself.
// s_tready is high only while the sequencer is idle; one request at a time.
// Every divide runs on the single frg_div unit: first the Euclid remainder
// steps, none when an input is zero, until a remainder is zero, then one
// divide for each quotient by the common divisor; s_tready returns in the
// same cycle as m_tvalid rises.
// A finished result sits in the output register; the next request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// sequencer holds it and accepts nothing until the register frees.
// Reset (aresetn low, synchronous) drops any request in flight and clears
// m_tvalid.
module fraction_reduce_gcd import frg_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // numerator, denominator
    input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // reduced_numerator, reduced_denominator, common_divisor
    output logic [((3*VALUE_WIDTH+7)/8)*8-1:0] m_tdata
);

    localparam int W  = VALUE_WIDTH;
    localparam int MW = ((3*VALUE_WIDTH+7)/8)*8;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        mag = x[W-1] ? (~x + 1'b1) : x;
    endfunction

    function automatic logic [W-1:0] with_sign(input logic [W-1:0] m, input logic neg);
        with_sign = neg ? (~m + 1'b1) : m;
    endfunction

    frg_state_t      state_reg, state_next;
    logic            start_reg, start_next;
    logic            mval_reg,  mval_next;
    logic [W-1:0]    n_reg,  n_next;
    logic [W-1:0]    d_reg,  d_next;
    logic [W-1:0]    a_reg,  a_next;
    logic [W-1:0]    b_reg,  b_next;
    logic [W-1:0]    qn_reg, qn_next;
    logic [W-1:0]    qd_reg, qd_next;
    logic [W-1:0]    on_reg, on_next;
    logic [W-1:0]    od_reg, od_next;
    logic [W-1:0]    og_reg, og_next;
    logic [W-1:0]    in_n, in_d, k;
    logic [W-1:0]    div_a, div_b, div_q, div_r;
    frg_div_status_t div_st;
    logic            s_acc;

    assign in_n  = s_tdata[W-1:0];
    assign in_d  = s_tdata[2*W-1:W];
    assign s_acc = s_tvalid && s_tready;
    assign k     = with_sign(div_r, a_reg[W-1]);

    always_comb begin
        unique case (state_reg)
            ST_QN:   begin div_a = mag(n_reg); div_b = mag(a_reg); end
            ST_QD:   begin div_a = mag(d_reg); div_b = mag(a_reg); end
            default: begin div_a = mag(a_reg); div_b = mag(b_reg); end
        endcase
    end

    frg_div #(.VALUE_WIDTH(W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (div_a),
        .divisor   (div_b),
        .status    (div_st),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb begin
        state_next = state_reg;
        start_next = 1'b0;
        mval_next  = mval_reg && !m_tready;
        n_next  = n_reg;
        d_next  = d_reg;
        a_next  = a_reg;
        b_next  = b_reg;
        qn_next = qn_reg;
        qd_next = qd_reg;
        on_next = on_reg;
        od_next = od_reg;
        og_next = og_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    n_next     = in_n;
                    d_next     = in_d;
                    start_next = 1'b1;
                    if (in_n == '0 || in_d == '0) begin
                        a_next     = W'(1);
                        state_next = ST_QN;
                    end else begin
                        if ($signed(in_d) > $signed(in_n)) begin
                            a_next = in_d;
                            b_next = in_n;
                        end else begin
                            a_next = in_n;
                            b_next = in_d;
                        end
                        state_next = ST_REM;
                    end
                end
            end
            ST_REM: begin
                if (div_st.done) begin
                    a_next     = b_reg;
                    b_next     = k;
                    start_next = 1'b1;
                    if (k == '0) state_next = ST_QN;
                end
            end
            ST_QN: begin
                if (div_st.done) begin
                    qn_next    = with_sign(div_q, n_reg[W-1] ^ a_reg[W-1]);
                    start_next = 1'b1;
                    state_next = ST_QD;
                end
            end
            ST_QD: begin
                if (div_st.done) begin
                    qd_next    = with_sign(div_q, d_reg[W-1] ^ a_reg[W-1]);
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!mval_reg || m_tready) begin
                    on_next    = qn_reg;
                    od_next    = qd_reg;
                    og_next    = a_reg;
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg  <= n_next;
        d_reg  <= d_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        qn_reg <= qn_next;
        qd_reg <= qd_next;
        on_reg <= on_next;
        od_reg <= od_next;
        og_reg <= og_next;
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= start_next;
            mval_reg  <= mval_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = mval_reg;
    assign m_tdata  = MW'({og_reg, od_reg, on_reg});

`ifndef SYNTH
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> (state_reg == ST_REM || state_reg == ST_QN || state_reg == ST_QD))
        else $error("divider result with no step waiting");
    a_gcd_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> og_reg != '0)
        else $error("zero common divisor");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg != ST_IDLE && start_reg)
        else $error("request taken without starting a divide");
`endif

endmodule
